// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg - shared types and constants for the MD5 hash engine
// Word structs, sequencer states, initial chaining value, padding constants,
// round constants, per-round rotate amounts and a rotate-left helper.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_LEN,
		ST_EMIT
	} state_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// rotate amount indexed by {quarter, round[1:0]}
	localparam logic [4:0] ROT_AMT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22,
		5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23,
		5'd6, 5'd10, 5'd15, 5'd21
	};

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] dbl;
		dbl = {v, v} << n;
		return dbl[63:32];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_hash_engine.sv =====
// ----------------------------------------------------------------------------
// md5_hash_engine - MD5 digest of a byte stream
// Packs bytes into a 64-byte block, runs the 64-round compression on one
// shared round unit, pads on end of message and emits four digest words.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------------
//  in      | into      | in_valid/in_stall  | in_t : byte, has_byte, end flag
//  out     | out of    | out_valid/out_stall| out_t: digest word, index, last
//
//  A byte word is taken while the sequencer is idle. The word that fills a
//  block starts 64 rounds and one chaining add, all on the single round unit.
//  End of message: padding bytes (up to 64) are written one by one, the
//  padding is closed, the length is written, and the padded tail runs one or
//  two compressions, then four digest words follow.
//  Reset gives the initial chaining value and an empty, zero-length message.
//  in_stall is high whenever the sequencer is not idle; out_stall holds the
//  current digest word and the sequencer with it.
//
`default_nettype none

module md5_hash_engine
	import md5_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_data
);

	state_t state_q, state_d;

	// chaining value and message bookkeeping
	logic [31:0] chain_q [4];
	logic [5:0]  pos_q;        // byte position inside the block
	logic [63:0] bits_q;       // message length in bits
	logic [31:0] asm_q;        // partially assembled block word
	logic        pad_pend_q;   // end seen, padding not finished
	logic        pad_first_q;  // 0x80 marker still to be placed
	logic        final_q;      // running compression is the last one
	logic [1:0]  idx_q;        // digest word being shown

	// round unit
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  rnd_q;

	// block store, written word-wise as bytes complete a word
	logic [31:0] blk_q [16];

	// sequencer controls
	logic        put_en;
	logic [7:0]  put_val;
	logic        start_round;
	logic        pad_done;

	logic [31:0] new_word;
	logic [31:0] f_val, m_val, sum_val, rot_val;
	logic [3:0]  g_idx;
	logic [3:0]  r4;

	assign pad_done = (pos_q == LEN_POS) && !pad_first_q;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.has_byte && pos_q == 6'd63)
						state_d = ST_ROUND;
					else if (in_data.end_of_message)
						state_d = ST_PAD;
				end
			end
			ST_ROUND: begin
				if (rnd_q == 6'd63)
					state_d = ST_ADD;
			end
			ST_ADD: begin
				if (final_q)
					state_d = ST_EMIT;
				else if (pad_pend_q)
					state_d = ST_PAD;
				else
					state_d = ST_IDLE;
			end
			ST_PAD: begin
				if (pad_done)
					state_d = ST_LEN;
				else if (pos_q == 6'd63)
					state_d = ST_ROUND;
			end
			ST_LEN: begin
				state_d = ST_ROUND;
			end
			ST_EMIT: begin
				if (!out_stall && idx_q == 2'd3)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- sequencer outputs ----------------
	always_comb begin
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		put_en      = 1'b0;
		put_val     = in_data.data_byte;
		start_round = (state_d == ST_ROUND) && (state_q != ST_ROUND);
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				put_en   = in_valid && in_data.has_byte;
			end
			ST_PAD: begin
				put_en  = !pad_done;
				put_val = pad_first_q ? PAD_MARK : 8'h00;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
			end
			ST_ROUND, ST_ADD, ST_LEN: begin
			end
			default: begin
			end
		endcase
	end

	assign out_data.digest_word = chain_q[idx_q];
	assign out_data.word_index  = idx_q;
	assign out_data.last_word   = (idx_q == 2'd3);

	// byte lane insert: lane 0 starts a fresh word
	assign new_word = (pos_q[1:0] == 2'd0) ? {24'd0, put_val}
		: (asm_q | ({24'd0, put_val} << {pos_q[1:0], 3'b000}));

	// ---------------- round function ----------------
	assign r4 = rnd_q[3:0];

	always_comb begin
		case (rnd_q[5:4])
			2'd0: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				g_idx = r4;
			end
			2'd1: begin
				f_val = (d_q & b_q) | (~d_q & c_q);
				g_idx = 4'(r4 * 4'd5 + 4'd1);
			end
			2'd2: begin
				f_val = b_q ^ c_q ^ d_q;
				g_idx = 4'(r4 * 4'd3 + 4'd5);
			end
			default: begin
				f_val = c_q ^ (b_q | ~d_q);
				g_idx = 4'(r4 * 4'd7);
			end
		endcase
	end

	assign m_val   = blk_q[g_idx];
	assign sum_val = a_q + f_val + ROUND_K[rnd_q] + m_val;
	assign rot_val = rotl32(sum_val, ROT_AMT[{rnd_q[5:4], rnd_q[1:0]}]);

	// ---------------- state and control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chain_q[0]  <= IV_A;
			chain_q[1]  <= IV_B;
			chain_q[2]  <= IV_C;
			chain_q[3]  <= IV_D;
			pos_q       <= '0;
			bits_q      <= '0;
			pad_pend_q  <= 1'b0;
			pad_first_q <= 1'b0;
			final_q     <= 1'b0;
			idx_q       <= '0;
			rnd_q       <= '0;
		end else begin
			state_q <= state_d;

			if (put_en)
				pos_q <= pos_q + 6'd1;

			if (state_q == ST_IDLE && in_valid) begin
				if (in_data.has_byte)
					bits_q <= bits_q + 64'd8;
				if (in_data.end_of_message) begin
					pad_pend_q  <= 1'b1;
					pad_first_q <= 1'b1;
				end
			end

			if (state_q == ST_PAD && put_en)
				pad_first_q <= 1'b0;

			if (state_q == ST_LEN) begin
				final_q    <= 1'b1;
				pad_pend_q <= 1'b0;
			end

			if (start_round)
				rnd_q <= '0;
			else if (state_q == ST_ROUND)
				rnd_q <= rnd_q + 6'd1;

			if (state_q == ST_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				idx_q      <= '0;
			end

			if (state_q == ST_EMIT && !out_stall) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					// digest out, back to a fresh message
					chain_q[0] <= IV_A;
					chain_q[1] <= IV_B;
					chain_q[2] <= IV_C;
					chain_q[3] <= IV_D;
					pos_q      <= '0;
					bits_q     <= '0;
					final_q    <= 1'b0;
				end
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (put_en)
			asm_q <= new_word;

		if (start_round) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == ST_ROUND) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot_val;
		end
	end

	always_ff @(posedge clk) begin
		if (put_en && pos_q[1:0] == 2'd3)
			blk_q[pos_q[5:2]] <= new_word;
		if (state_q == ST_LEN) begin
			blk_q[14] <= bits_q[31:0];
			blk_q[15] <= bits_q[63:32];
		end
	end

	// ---------------- checks ----------------
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall))
		else $error("input taken while digest pending");

	a_rounds_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> (rnd_q == 6'd0))
		else $error("chaining add before 64 rounds");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEN) |-> (pos_q == LEN_POS && !pad_first_q))
		else $error("length written at wrong block position");

	a_chain_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.last_word) |=>
		(chain_q[0] == IV_A && pos_q == 6'd0 && bits_q == 64'd0))
		else $error("state not reinitialised after digest");

endmodule

`default_nettype wire
